@@ rtl/ntn_pkg.sv @@
// Shared types and constants for the number text normaliser.
package ntn_pkg;

    // Character codes used by the normalising rules.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Configuration port geometry and register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_NUMBER_MODE = 1'b0;

    // Number mode values.
    localparam logic MODE_DECIMAL = 1'b0;

    // Most result items that one input item can cause.
    localparam int MAX_RESULTS = 3;
    localparam int COUNT_W     = 2;

    // Progress through the current string.
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SKIP  = 2'd1,
        PH_PASS  = 2'd2
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_ch;
        logic       has_char;
        logic       last;
    } item_t;

    // The results of one input item, in order from entry 0, with their count.
    typedef struct packed {
        item_t [MAX_RESULTS-1:0] items;
        logic  [COUNT_W-1:0]     count;
    } result_set_t;

endpackage

@@ rtl/ntn_decode.sv @@
// String state and result generation for one input character or end item.
module ntn_decode
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          ch,
    input  logic                end_marker,
    input  logic                number_mode,
    output ntn_pkg::result_set_t results
);

    localparam int MAX_RESULTS = ntn_pkg::MAX_RESULTS;
    typedef ntn_pkg::item_t item_t;

    ntn_pkg::phase_t phase_reg;
    ntn_pkg::phase_t phase_next;
    logic            negative_reg;
    logic            negative_next;
    logic            dot_seen_reg;
    logic            dot_seen_next;
    logic            awaiting_reg;
    logic            awaiting_next;

    logic            dec;
    logic            early;
    logic            is_digit;
    logic            first_dot;

    assign dec       = (number_mode == ntn_pkg::MODE_DECIMAL);
    assign early     = (phase_reg != ntn_pkg::PH_PASS);
    assign is_digit  = (ch >= ntn_pkg::CH_ZERO) && (ch <= ntn_pkg::CH_NINE);
    assign first_dot = dec && (ch == ntn_pkg::CH_DOT) && !dot_seen_reg;

    // Next string state.
    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        dot_seen_next = dot_seen_reg;
        awaiting_next = awaiting_reg;
        if (end_marker)
        begin
            phase_next    = ntn_pkg::PH_START;
            negative_next = 1'b0;
            dot_seen_next = 1'b0;
            awaiting_next = 1'b0;
        end
        else if (ch != ntn_pkg::CH_PLUS)
        begin
            if (early && (phase_reg == ntn_pkg::PH_START) && (ch == ntn_pkg::CH_MINUS))
            begin
                negative_next = 1'b1;
                phase_next    = ntn_pkg::PH_SKIP;
            end
            else if (early && (ch == ntn_pkg::CH_ZERO))
            begin
                phase_next = ntn_pkg::PH_SKIP;
            end
            else
            begin
                phase_next    = ntn_pkg::PH_PASS;
                awaiting_next = 1'b0;
                if (first_dot)
                begin
                    dot_seen_next = 1'b1;
                    awaiting_next = 1'b1;
                end
            end
        end
    end

    // Result items for the current input item.
    always_comb
    begin
        logic  emit_minus;
        logic  emit_zero;
        logic  emit_main;
        item_t main_item;
        item_t minus_item;
        item_t zero_item;

        emit_minus = 1'b0;
        emit_zero  = 1'b0;
        emit_main  = 1'b0;
        main_item  = '{out_ch: ch, has_char: 1'b1, last: 1'b0};
        minus_item = '{out_ch: ntn_pkg::CH_MINUS, has_char: 1'b1, last: 1'b0};
        zero_item  = '{out_ch: ntn_pkg::CH_ZERO, has_char: 1'b1, last: 1'b0};

        if (end_marker)
        begin
            emit_main = 1'b1;
            if (early)
            begin
                emit_minus = negative_reg;
                main_item  = '{out_ch: ntn_pkg::CH_ZERO, has_char: 1'b1, last: 1'b1};
            end
            else if (awaiting_reg)
            begin
                main_item = '{out_ch: ntn_pkg::CH_ZERO, has_char: 1'b1, last: 1'b1};
            end
            else
            begin
                main_item = '{out_ch: 8'h00, has_char: 1'b0, last: 1'b1};
            end
        end
        else if (ch != ntn_pkg::CH_PLUS)
        begin
            if (early)
            begin
                if (!((phase_reg == ntn_pkg::PH_START) && (ch == ntn_pkg::CH_MINUS))
                    && (ch != ntn_pkg::CH_ZERO))
                begin
                    emit_main  = 1'b1;
                    emit_minus = negative_reg;
                    emit_zero  = dec && (ch == ntn_pkg::CH_DOT);
                end
            end
            else
            begin
                emit_main = 1'b1;
                emit_zero = awaiting_reg && !is_digit;
            end
        end

        // Pack the emitted items from entry 0 upwards.
        results.items = {MAX_RESULTS{main_item}};
        results.count = '0;
        if (emit_main)
        begin
            case ({emit_minus, emit_zero})
                2'b00:
                begin
                    results.items[0] = main_item;
                    results.count    = 2'd1;
                end
                2'b10:
                begin
                    results.items[0] = minus_item;
                    results.items[1] = main_item;
                    results.count    = 2'd2;
                end
                2'b01:
                begin
                    results.items[0] = zero_item;
                    results.items[1] = main_item;
                    results.count    = 2'd2;
                end
                default:
                begin
                    results.items[0] = minus_item;
                    results.items[1] = zero_item;
                    results.items[2] = main_item;
                    results.count    = 2'd3;
                end
            endcase
        end
    end

    // String state registers, updated on each accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ntn_pkg::PH_START;
            negative_reg <= 1'b0;
            dot_seen_reg <= 1'b0;
            awaiting_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            dot_seen_reg <= dot_seen_next;
            awaiting_reg <= awaiting_next;
        end
    end

endmodule

@@ rtl/ntn_out_buf.sv @@
// Result register holding up to three pending result items, sent one per cycle while pop is high.
module ntn_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  ntn_pkg::result_set_t results,
    input  logic                 pop,
    output logic                 can_load,
    output logic                 valid,
    output ntn_pkg::item_t       head
);

    ntn_pkg::item_t [ntn_pkg::MAX_RESULTS-1:0] items_reg;
    ntn_pkg::item_t [ntn_pkg::MAX_RESULTS-1:0] items_next;
    logic [ntn_pkg::COUNT_W-1:0]               count_reg;
    logic [ntn_pkg::COUNT_W-1:0]               count_next;

    assign valid    = (count_reg != '0);
    assign head     = items_reg[0];
    assign can_load = (count_reg == '0) || ((count_reg == 2'd1) && pop);

    // Either take a fresh set of results or move the queue up by one.
    always_comb
    begin
        items_next = items_reg;
        count_next = count_reg;
        if (load)
        begin
            items_next = results.items;
            count_next = results.count;
        end
        else if (pop)
        begin
            items_next[0] = items_reg[1];
            items_next[1] = items_reg[2];
            count_next    = count_reg - 2'd1;
        end
    end

    // Count of pending items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Pending item payloads.
    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

endmodule

@@ rtl/number_text_normalizer_unit.sv @@
// Top level of the number text normaliser: stream ports, register port and glue.
//
// The input stream carries one character per transfer in s_axis_tdata; a transfer
// with s_axis_tlast high is the end item of a string and its character is ignored.
// The output stream carries the normalised text one character per transfer, with
// m_axis_tuser high when m_axis_tdata holds a character and m_axis_tlast high on
// the final transfer of each string. '+' is dropped, leading zeros are skipped,
// "0" or "-0" stands in for an empty string, and in decimal mode a zero is put
// before a leading dot and after the first dot if a non-digit or the end follows it.
// One input transfer gives zero to three output transfers, all computed in the
// cycle it is accepted and held in a three-entry result register. A character
// giving one result flows at one transfer per cycle while the receiver is ready;
// one giving more holds the output until each has left the single output port of
// the result register. A new character is taken while the last pending result is
// being sent. When the receiver stalls, results wait in the register and
// s_axis_tready stays low while any result is pending, apart from the cycle in
// which the last one is taken. Reset clears the string state, the pending results
// and number_mode. The user writes number_mode (byte address 0, bit 0) over the
// register port only while idle; the block itself does not enforce this.
module number_text_normalizer_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] ch
    input  logic                           s_axis_tlast,   // end_marker
    // Output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] out_ch
    output logic                           m_axis_tuser,   // [0] has_char
    output logic                           m_axis_tlast,   // last
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ntn_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic                 number_mode_reg;
    logic                 number_mode_next;
    logic                 cfg_write;
    logic                 in_fire;
    logic                 out_fire;
    logic                 can_load;
    ntn_pkg::result_set_t results;
    ntn_pkg::item_t       head;

    // Register port decode.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ntn_pkg::REG_NUMBER_MODE) ? {31'b0, number_mode_reg} : '0;

    always_comb
    begin
        number_mode_next = number_mode_reg;
        if (cfg_write && (paddr[2] == ntn_pkg::REG_NUMBER_MODE))
        begin
            number_mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_mode_reg <= 1'b0;
        end
        else
        begin
            number_mode_reg <= number_mode_next;
        end
    end

    // Stream handshakes.
    assign s_axis_tready = can_load;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    // Result generation and string state.
    ntn_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (in_fire),
        .ch          (s_axis_tdata),
        .end_marker  (s_axis_tlast),
        .number_mode (number_mode_reg),
        .results     (results)
    );

    // Result register.
    ntn_out_buf u_out_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_fire),
        .results  (results),
        .pop      (out_fire),
        .can_load (can_load),
        .valid    (m_axis_tvalid),
        .head     (head)
    );

    assign m_axis_tdata = head.out_ch;
    assign m_axis_tuser = head.has_char;
    assign m_axis_tlast = head.last;

endmodule

@@ tb/ntn_result_check.sv @@
// Result checker for the number text normaliser: predicts each output transfer and compares it.
module ntn_result_check
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] ch
    input  logic                           s_axis_tlast,   // end_marker
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [7:0]                     m_axis_tdata,   // [7:0] out_ch
    input  logic                           m_axis_tuser,   // [0] has_char
    input  logic                           m_axis_tlast,   // last
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ntn_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    output int                             mismatches,
    output int                             pending
);

    localparam logic [ntn_pkg::CFG_ADDR_W-1:0] MODE_ADDR = {ntn_pkg::REG_NUMBER_MODE, 2'b00};

    // Own copy of the string state and of the mode register.
    ntn_pkg::phase_t text_phase;
    logic            sign_held;
    logic            first_dot_done;
    logic            zero_due;
    logic            number_mode_copy;

    ntn_pkg::item_t  normalised_q[$];
    ntn_pkg::item_t  got;
    ntn_pkg::item_t  want;
    int              fault_count;

    // Queues one expected output transfer.
    function void want_result(input logic [7:0] c, input logic has, input logic fin);
        ntn_pkg::item_t r;
        r.out_ch   = c;
        r.has_char = has;
        r.last     = fin;
        normalised_q.push_back(r);
    endfunction

    function void clear_text();
        text_phase     = ntn_pkg::PH_START;
        sign_held      = 1'b0;
        first_dot_done = 1'b0;
        zero_due       = 1'b0;
    endfunction

    // Works out what one accepted input item produces and advances the state.
    function void normalise_step(input logic [7:0] c, input logic stop);
        logic decimal;
        decimal = (number_mode_copy == ntn_pkg::MODE_DECIMAL);
        if (stop)
        begin
            if (text_phase != ntn_pkg::PH_PASS)
            begin
                if (sign_held)
                    want_result(ntn_pkg::CH_MINUS, 1'b1, 1'b0);
                want_result(ntn_pkg::CH_ZERO, 1'b1, 1'b1);
            end
            else if (zero_due)
                want_result(ntn_pkg::CH_ZERO, 1'b1, 1'b1);
            else
                want_result(8'h00, 1'b0, 1'b1);
            clear_text();
            return;
        end
        if (c == ntn_pkg::CH_PLUS)
            return;
        if (text_phase != ntn_pkg::PH_PASS)
        begin
            // Only the very first kept '-' becomes the sign; zeros are skipped.
            if (text_phase == ntn_pkg::PH_START && c == ntn_pkg::CH_MINUS)
            begin
                sign_held  = 1'b1;
                text_phase = ntn_pkg::PH_SKIP;
                return;
            end
            if (c == ntn_pkg::CH_ZERO)
            begin
                text_phase = ntn_pkg::PH_SKIP;
                return;
            end
            if (sign_held)
                want_result(ntn_pkg::CH_MINUS, 1'b1, 1'b0);
            if (decimal && c == ntn_pkg::CH_DOT)
                want_result(ntn_pkg::CH_ZERO, 1'b1, 1'b0);
            text_phase = ntn_pkg::PH_PASS;
        end
        else if (zero_due)
        begin
            // The first dot followed by a non-digit gets a zero in between.
            if (c < ntn_pkg::CH_ZERO || c > ntn_pkg::CH_NINE)
                want_result(ntn_pkg::CH_ZERO, 1'b1, 1'b0);
            zero_due = 1'b0;
        end
        want_result(c, 1'b1, 1'b0);
        if (decimal && c == ntn_pkg::CH_DOT && !first_dot_done)
        begin
            first_dot_done = 1'b1;
            zero_due       = 1'b1;
        end
    endfunction

    function void note_fault(input string what);
        fault_count++;
        if (fault_count <= 10)
            $display({"result_check: %s at %0t: expected ch=%02h has=%b last=%b,",
                      " got ch=%02h has=%b last=%b"},
                     what, $realtime, want.out_ch, want.has_char, want.last,
                     got.out_ch, got.has_char, got.last);
    endfunction

    // Output transfers come from earlier inputs, so they are checked before the
    // input transfer of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_text();
            number_mode_copy = ntn_pkg::MODE_DECIMAL;
            normalised_q.delete();
            fault_count = 0;
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.out_ch   = m_axis_tdata;
                got.has_char = m_axis_tuser;
                got.last     = m_axis_tlast;
                if (normalised_q.size() == 0)
                begin
                    want = '0;
                    note_fault("unexpected transfer");
                end
                else
                begin
                    want = normalised_q.pop_front();
                    if (got.out_ch !== want.out_ch || got.has_char !== want.has_char ||
                        got.last !== want.last)
                        note_fault("mismatch");
                end
            end
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
                number_mode_copy = pwdata[0];
            if (s_axis_tvalid && s_axis_tready)
                normalise_step(s_axis_tdata, s_axis_tlast);
            mismatches <= fault_count;
            pending    <= normalised_q.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the number text normaliser: stimulus, receiver stalls and verdict.
module tb;

    localparam logic MODE_INTEGER = ~ntn_pkg::MODE_DECIMAL;
    localparam logic [ntn_pkg::CFG_ADDR_W-1:0] MODE_ADDR = {ntn_pkg::REG_NUMBER_MODE, 2'b00};
    localparam logic [7:0]            CH_E_LOWER    = 8'h65;
    localparam logic [7:0]            CH_E_UPPER    = 8'h45;
    localparam int                    SETTLE_CYCLES = 8;
    localparam int                    CYCLE_LIMIT   = 200000;
    localparam int                    PHASE_ITEMS   = 60;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata;   // [7:0] ch
    logic                           s_axis_tlast;   // end_marker
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [7:0]                     m_axis_tdata;   // [7:0] out_ch
    logic                           m_axis_tuser;   // [0] has_char
    logic                           m_axis_tlast;   // last
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ntn_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    int         mismatches;
    int         pending;
    int         cycles;
    int         counted;
    int         rx_hold;
    bit         steady;
    logic [7:0] text_q[$];
    string      mix_chars = "+-.0123456789eE/:";

    number_text_normalizer_unit DUT (.*);
    ntn_result_check result_check (.*);

    // Clock and cycle limit.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Number of idle cycles before the next transfer on either side.
    function automatic int idle_draw();
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] rand_digit();
        return ntn_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Receiver: after each transfer it may hold tready low for a while.
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            rx_hold = idle_draw();
            if (rx_hold > 0)
                m_axis_tready <= 1'b0;
        end
        else if (!m_axis_tready)
        begin
            if (rx_hold > 0)
                rx_hold--;
            if (rx_hold == 0)
                m_axis_tready <= 1'b1;
        end
    end

    // Offers one input item and returns at the edge where it is taken.
    task automatic send_item(input logic [7:0] ch, input logic stop);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= stop;
        do @(posedge clk); while (!s_axis_tready);
        if (stop || ch != ntn_pkg::CH_PLUS)
            counted++;
    endtask

    task automatic send_word(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
        if (close)
            send_item(8'($urandom), 1'b1);
    endtask

    // Holds the input back until every expected result has been seen.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {31'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Builds one string: mostly well-formed numbers, some broken ones and some noise.
    task automatic send_random_string();
        int shape;
        int n;
        text_q.delete();
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) text_q.push_back(8'($urandom));
        end
        else if (shape == 1)
        begin
            n = $urandom_range(1, 8);
            repeat (n) text_q.push_back(mix_chars[$urandom_range(0, mix_chars.len() - 1)]);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: text_q.push_back(ntn_pkg::CH_MINUS);
                1: text_q.push_back(ntn_pkg::CH_PLUS);
                default: ;
            endcase
            repeat ($urandom_range(0, 3)) text_q.push_back(ntn_pkg::CH_ZERO);
            repeat ($urandom_range(0, 4)) text_q.push_back(rand_digit());
            if ($urandom_range(0, 1) == 1)
            begin
                text_q.push_back(ntn_pkg::CH_DOT);
                repeat ($urandom_range(0, 3)) text_q.push_back(rand_digit());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                text_q.push_back($urandom_range(0, 1) ? CH_E_LOWER : CH_E_UPPER);
                case ($urandom_range(0, 2))
                    0: text_q.push_back(ntn_pkg::CH_MINUS);
                    1: text_q.push_back(ntn_pkg::CH_PLUS);
                    default: ;
                endcase
                repeat ($urandom_range(1, 2)) text_q.push_back(rand_digit());
            end
        end
        steady = ($urandom_range(0, 5) == 0);
        foreach (text_q[i])
        begin
            if (shape > 1 && $urandom_range(0, 9) == 0)
                send_item(ntn_pkg::CH_PLUS, 1'b0);
            send_item(text_q[i], 1'b0);
        end
        send_item(8'($urandom), 1'b1);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cycles        <= 0;
        rx_hold        = 0;
        steady         = 1'b0;
        counted        = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings in decimal mode.
        write_mode(ntn_pkg::MODE_DECIMAL);
        send_word("", 1'b1);            // empty text gives a lone zero
        send_word("+-00", 1'b1);        // dropped plus, sign and skipped zeros
        send_word("-..", 1'b1);         // sign and zero before a leading dot, zero before the later dot
        send_word("2.", 1'b1);          // pending zero after the dot closes the string
        send_word("0-", 1'b1);          // a minus after zeros is an ordinary character
        send_item(8'hFF, 1'b0);         // character code extremes pass through
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        // Mode switched while a zero after the dot is still pending.
        send_word("3.", 1'b0);
        write_mode(MODE_INTEGER);
        send_word("x", 1'b1);

        // Random strings, alternating the mode, with occasional full drains.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_mode((ph % 2 == 0) ? ntn_pkg::MODE_DECIMAL : MODE_INTEGER);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                send_random_string();
                if ($urandom_range(0, 15) == 0)
                    drain();
            end
        end

        steady = 1'b0;
        drain();
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
